// ----- rtl/cmpa_pkg.sv -----
// Shared types and constants for the 3x4 color matrix pixel pipeline.
package cmpa_pkg;

  localparam int CHAN_W     = 8;
  localparam int COEF_W     = 16;
  localparam int COL_W      = 64;
  localparam int PIX_W      = 32;
  localparam int FRAC       = 12;
  localparam int OFFS_SHIFT = 6;
  // 9-bit unsigned-as-signed times s3.12
  localparam int PROD_W     = CHAN_W + 1 + COEF_W;
  // three products plus shifted offset
  localparam int ACC_W      = PROD_W + 2;

  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

  localparam logic [COL_W-1:0] RED_COL_RST   = 64'h0000_0000_0000_1000;
  localparam logic [COL_W-1:0] GREEN_COL_RST = 64'h0000_0000_1000_0000;
  localparam logic [COL_W-1:0] BLUE_COL_RST  = 64'h0000_1000_0000_0000;

  typedef enum logic [1:0] {
    CFG_RED   = 2'd0,
    CFG_GREEN = 2'd1,
    CFG_BLUE  = 2'd2
  } cfg_idx_t;

  // per-stage load enables
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

endpackage

// ----- rtl/color_matrix_pixel_apply.sv -----
// Top level of the 3x4 affine color matrix pixel pipeline.
//
// Input channel: in_valid/in_ready carry in_pixel_in (first byte, red,
// green, blue). Output channel: out_valid/out_ready carry out_pixel_out in
// the same packing; the first byte is copied, each color is the weighted
// sum of red, green and blue plus an offset, truncated and clamped 0..255.
// Config channel: cfg_valid/cfg_ready with cfg_index (0 red, 1 green,
// 2 blue column) and cfg_data; other indexes are ignored. cfg_ready is
// always high; write only while the pipeline is empty.
// Each input transfer passes through the products, sum and clamp stage
// registers to out_valid. Throughput: one pixel per cycle while out_ready is high.
// Each stage holds when the one after it is full and stalled, so a held
// out_ready fills the pipeline and then drops in_ready; bubbles collapse.
// Reset: empties the pipeline and loads the identity matrix.
module color_matrix_pixel_apply (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [cmpa_pkg::PIX_W-1:0]    in_pixel_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cmpa_pkg::PIX_W-1:0]    out_pixel_out,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [cmpa_pkg::COL_W-1:0]    cfg_data
);

  logic [cmpa_pkg::COL_W-1:0]  red_col_r;
  logic [cmpa_pkg::COL_W-1:0]  green_col_r;
  logic [cmpa_pkg::COL_W-1:0]  blue_col_r;
  logic                        v1_r, v2_r, v3_r;
  logic                        v1_nxt, v2_nxt, v3_nxt;
  logic [cmpa_pkg::CHAN_W-1:0] byte1_r, byte2_r, byte3_r;
  logic [cmpa_pkg::CHAN_W-1:0] red_out, green_out, blue_out;
  cmpa_pkg::stage_en_t         en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_col_r   <= cmpa_pkg::RED_COL_RST;
      green_col_r <= cmpa_pkg::GREEN_COL_RST;
      blue_col_r  <= cmpa_pkg::BLUE_COL_RST;
    end else if (cfg_valid) begin
      unique case (cmpa_pkg::cfg_idx_t'(cfg_index))
        cmpa_pkg::CFG_RED:   red_col_r   <= cfg_data;
        cmpa_pkg::CFG_GREEN: green_col_r <= cfg_data;
        cmpa_pkg::CFG_BLUE:  blue_col_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage enables
  always_comb begin
    en.s3  = !v3_r || out_ready;
    en.s2  = !v2_r || en.s3;
    en.s1  = !v1_r || en.s2;
    v1_nxt = en.s1 ? in_valid : v1_r;
    v2_nxt = en.s2 ? v1_r : v2_r;
    v3_nxt = en.s3 ? v2_r : v3_r;
  end

  assign in_ready = en.s1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      byte1_r <= in_pixel_in[31:24];
    end
    if (en.s2) begin
      byte2_r <= byte1_r;
    end
    if (en.s3) begin
      byte3_r <= byte2_r;
    end
  end

  cmpa_channel u_red (
    .clk      (clk),
    .en       (en),
    .red      (in_pixel_in[23:16]),
    .green    (in_pixel_in[15:8]),
    .blue     (in_pixel_in[7:0]),
    .column   (red_col_r),
    .chan_out (red_out)
  );

  cmpa_channel u_green (
    .clk      (clk),
    .en       (en),
    .red      (in_pixel_in[23:16]),
    .green    (in_pixel_in[15:8]),
    .blue     (in_pixel_in[7:0]),
    .column   (green_col_r),
    .chan_out (green_out)
  );

  cmpa_channel u_blue (
    .clk      (clk),
    .en       (en),
    .red      (in_pixel_in[23:16]),
    .green    (in_pixel_in[15:8]),
    .blue     (in_pixel_in[7:0]),
    .column   (blue_col_r),
    .chan_out (blue_out)
  );

  assign out_valid     = v3_r;
  assign out_pixel_out = {byte3_r, red_out, green_out, blue_out};

endmodule

// ----- rtl/cmpa_channel.sv -----
// One output channel datapath: multiply, sum with offset, truncate and clamp.
module cmpa_channel (
  input  logic                             clk,
  input  cmpa_pkg::stage_en_t              en,
  input  logic [cmpa_pkg::CHAN_W-1:0]      red,
  input  logic [cmpa_pkg::CHAN_W-1:0]      green,
  input  logic [cmpa_pkg::CHAN_W-1:0]      blue,
  input  logic [cmpa_pkg::COL_W-1:0]       column,
  output logic [cmpa_pkg::CHAN_W-1:0]      chan_out
);

  logic signed [cmpa_pkg::PROD_W-1:0] prod_red_r;
  logic signed [cmpa_pkg::PROD_W-1:0] prod_green_r;
  logic signed [cmpa_pkg::PROD_W-1:0] prod_blue_r;
  logic signed [cmpa_pkg::COEF_W-1:0] offs_r;
  logic signed [cmpa_pkg::ACC_W-1:0]  acc_nxt;
  logic signed [cmpa_pkg::ACC_W-1:0]  acc_r;
  logic [cmpa_pkg::CHAN_W-1:0]        chan_nxt;
  logic [cmpa_pkg::CHAN_W-1:0]        chan_r;

  // stage 1: products
  always_ff @(posedge clk) begin
    if (en.s1) begin
      prod_red_r   <= $signed({1'b0, red})   * $signed(column[15:0]);
      prod_green_r <= $signed({1'b0, green}) * $signed(column[31:16]);
      prod_blue_r  <= $signed({1'b0, blue})  * $signed(column[47:32]);
      offs_r       <= $signed(column[63:48]);
    end
  end

  // stage 2: sum in 2^-12 units
  always_comb begin
    acc_nxt = cmpa_pkg::ACC_W'(prod_red_r) + cmpa_pkg::ACC_W'(prod_green_r)
            + cmpa_pkg::ACC_W'(prod_blue_r)
            + $signed({{(cmpa_pkg::ACC_W - cmpa_pkg::COEF_W - cmpa_pkg::OFFS_SHIFT)
                         {offs_r[cmpa_pkg::COEF_W-1]}},
                       offs_r, {cmpa_pkg::OFFS_SHIFT{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      acc_r <= acc_nxt;
    end
  end

  // stage 3: truncate and clamp
  always_comb begin
    if (acc_r[cmpa_pkg::ACC_W-1]) begin
      chan_nxt = '0;
    end else if (|acc_r[cmpa_pkg::ACC_W-2:cmpa_pkg::FRAC+cmpa_pkg::CHAN_W]) begin
      chan_nxt = cmpa_pkg::CHAN_MAX;
    end else begin
      chan_nxt = acc_r[cmpa_pkg::FRAC+cmpa_pkg::CHAN_W-1:cmpa_pkg::FRAC];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      chan_r <= chan_nxt;
    end
  end

  assign chan_out = chan_r;

endmodule

// ----- rtl/cmpa_checker.sv -----
// Port-level assertions for the color matrix pipeline, bound to the top level.
module cmpa_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [cmpa_pkg::PIX_W-1:0] out_pixel_out
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

  a_ready_on_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |-> in_ready)
    else $error("input stalled while output transfers");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_pixel_out)))
    else $error("stalled output changed");

endmodule

bind color_matrix_pixel_apply cmpa_checker u_cmpa_checker (.*);

// ----- tb/tb_color_matrix_pixel_apply.sv -----
// Self-checking testbench for the 3x4 color matrix pixel pipeline.
module tb_color_matrix_pixel_apply;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam longint     OFFS_SCALE =
    longint'(1) << (cmpa_pkg::FRAC - cmpa_pkg::OFFS_SHIFT);
  localparam int         DRAIN_AT   = 700;
  localparam int         RAND_PHASES = 10;
  localparam int         PHASE_PIXELS = 145;

  typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_PERIODIC} rdy_mode_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [cmpa_pkg::PIX_W-1:0] in_pixel_in = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [cmpa_pkg::PIX_W-1:0] out_pixel_out;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [1:0]                 cfg_index = '0;
  logic [cmpa_pkg::COL_W-1:0] cfg_data = '0;

  logic [cmpa_pkg::COL_W-1:0] matrix_col [3];
  logic [cmpa_pkg::PIX_W-1:0] pending_px [$];
  logic [cmpa_pkg::PIX_W-1:0] expected_px [$];
  logic [cmpa_pkg::PIX_W-1:0] want_px;
  int               err_cnt = 0;
  int               sent_cnt = 0;
  int               burst_left = 0;
  int               gap_left = 0;
  bit               drain_wait = 0;
  bit               drained_once = 0;
  rdy_mode_t        rdy_mode = RDY_ALWAYS;
  int               rdy_left = 0;
  int               rdy_phase = 0;

  color_matrix_pixel_apply DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_pixel_in  (in_pixel_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_pixel_out(out_pixel_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [cmpa_pkg::CHAN_W-1:0] mix_channel(
    logic [cmpa_pkg::COL_W-1:0]  col,
    logic [cmpa_pkg::CHAN_W-1:0] r,
    logic [cmpa_pkg::CHAN_W-1:0] g,
    logic [cmpa_pkg::CHAN_W-1:0] b);
    longint acc;
    acc = longint'(r) * longint'($signed(col[15:0]))
        + longint'(g) * longint'($signed(col[31:16]))
        + longint'(b) * longint'($signed(col[47:32]))
        + longint'($signed(col[63:48])) * OFFS_SCALE;
    if (acc < 0) return '0;
    acc = acc >>> cmpa_pkg::FRAC;
    if (acc > longint'(cmpa_pkg::CHAN_MAX)) return cmpa_pkg::CHAN_MAX;
    return acc[cmpa_pkg::CHAN_W-1:0];
  endfunction

  function automatic logic [cmpa_pkg::PIX_W-1:0] apply_matrix(
    logic [cmpa_pkg::PIX_W-1:0] px);
    return {px[31:24],
            mix_channel(matrix_col[cmpa_pkg::CFG_RED],   px[23:16], px[15:8], px[7:0]),
            mix_channel(matrix_col[cmpa_pkg::CFG_GREEN], px[23:16], px[15:8], px[7:0]),
            mix_channel(matrix_col[cmpa_pkg::CFG_BLUE],  px[23:16], px[15:8], px[7:0])};
  endfunction

  function automatic logic [cmpa_pkg::CHAN_W-1:0] rand_byte();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return cmpa_pkg::CHAN_MAX;
      default: return cmpa_pkg::CHAN_W'($urandom);
    endcase
  endfunction

  function automatic logic [cmpa_pkg::PIX_W-1:0] rand_pixel();
    if ($urandom_range(0, 1) == 0) return cmpa_pkg::PIX_W'($urandom);
    return {rand_byte(), rand_byte(), rand_byte(), rand_byte()};
  endfunction

  // mostly moderate weights (about +-1.5) and offsets (about +-128)
  function automatic logic [cmpa_pkg::COL_W-1:0] rand_column();
    int cr, cg, cb, off;
    if ($urandom_range(0, 3) == 0) return {$urandom, $urandom};
    cr  = int'($urandom_range(0, 12288)) - 6144;
    cg  = int'($urandom_range(0, 12288)) - 6144;
    cb  = int'($urandom_range(0, 12288)) - 6144;
    off = int'($urandom_range(0, 16384)) - 8192;
    return {16'(off), 16'(cb), 16'(cg), 16'(cr)};
  endfunction

  task automatic report_mismatch(string what, logic [cmpa_pkg::PIX_W-1:0] got,
                                 logic [cmpa_pkg::PIX_W-1:0] want);
    err_cnt++;
    if (err_cnt <= 50)
      $display("%0t: %s: got %08h want %08h", $realtime, what, got, want);
  endtask

  task automatic write_column(logic [1:0] idx, logic [cmpa_pkg::COL_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx != CFG_UNUSED) matrix_col[idx] = val;
  endtask

  task automatic wait_idle();
    while (pending_px.size() != 0 || expected_px.size() != 0) @(posedge clk);
  endtask

  // driver: bursts with random gaps, occasional full drain
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_px.push_back(apply_matrix(in_pixel_in));
        void'(pending_px.pop_front());
        sent_cnt++;
        if (burst_left > 0) burst_left--;
      end
      if (drain_wait && expected_px.size() == 0) drain_wait = 0;
      if (!(in_valid && !in_ready)) begin
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(1, 20);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          if ((!drained_once && sent_cnt >= DRAIN_AT) || $urandom_range(0, 30) == 0) begin
            drain_wait = 1;
            drained_once = 1;
          end
        end
        if (gap_left > 0 || drain_wait || pending_px.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          in_valid    <= 1'b1;
          in_pixel_in <= pending_px[0];
        end
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      rdy_phase++;
      if (rdy_left == 0) begin
        rdy_mode = rdy_mode_t'($urandom_range(0, 3));
        rdy_left = $urandom_range(10, 200);
      end else begin
        rdy_left--;
      end
      case (rdy_mode)
        RDY_ALWAYS:   out_ready <= 1'b1;
        RDY_COIN:     out_ready <= 1'($urandom_range(0, 1));
        RDY_SPARSE:   out_ready <= ($urandom_range(0, 7) == 0);
        RDY_PERIODIC: out_ready <= ((rdy_phase % 16) < 11);
        default:      out_ready <= 1'b1;
      endcase
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_px.size() == 0) begin
        report_mismatch("unexpected transfer", out_pixel_out, 'x);
      end else begin
        want_px = expected_px.pop_front();
        if (out_pixel_out !== want_px)
          report_mismatch("pixel_out mismatch", out_pixel_out, want_px);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    matrix_col[cmpa_pkg::CFG_RED]   = cmpa_pkg::RED_COL_RST;
    matrix_col[cmpa_pkg::CFG_GREEN] = cmpa_pkg::GREEN_COL_RST;
    matrix_col[cmpa_pkg::CFG_BLUE]  = cmpa_pkg::BLUE_COL_RST;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // identity after reset
    @(negedge clk);
    pending_px.push_back(32'h0000_0000);
    pending_px.push_back(32'hFFFF_FFFF);
    pending_px.push_back(32'h1234_5678);
    pending_px.push_back(32'h80FF_0001);
    pending_px.push_back(32'h7F00_FF80);
    pending_px.push_back(32'hA5C3_5A3C);
    wait_idle();

    // largest weights and offset: everything saturates
    write_column(cmpa_pkg::CFG_RED,   64'h7FFF_7FFF_7FFF_7FFF);
    write_column(cmpa_pkg::CFG_GREEN, 64'h7FFF_7FFF_7FFF_7FFF);
    write_column(cmpa_pkg::CFG_BLUE,  64'h7FFF_7FFF_7FFF_7FFF);
    @(negedge clk);
    pending_px.push_back(32'h0000_0000);
    pending_px.push_back(32'hFFFF_FFFF);
    pending_px.push_back(32'h5A01_0203);
    wait_idle();

    // most negative weights and offset: everything clamps to zero
    write_column(cmpa_pkg::CFG_RED,   64'h8000_8000_8000_8000);
    write_column(cmpa_pkg::CFG_GREEN, 64'h8000_8000_8000_8000);
    write_column(cmpa_pkg::CFG_BLUE,  64'h8000_8000_8000_8000);
    @(negedge clk);
    pending_px.push_back(32'h0000_0000);
    pending_px.push_back(32'hFFFF_FFFF);
    pending_px.push_back(32'hC380_8080);
    wait_idle();

    // red - 0.5 truncates, 256 - red saturates, 2 * blue saturates
    write_column(cmpa_pkg::CFG_RED,   64'hFFE0_0000_0000_1000);
    write_column(cmpa_pkg::CFG_GREEN, 64'h4000_0000_0000_F000);
    write_column(cmpa_pkg::CFG_BLUE,  64'h0000_2000_0000_0000);
    write_column(CFG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    @(negedge clk);
    pending_px.push_back(32'h0000_0000);
    pending_px.push_back(32'h0101_0101);
    pending_px.push_back(32'hFF7F_80FF);
    pending_px.push_back(32'h10FE_0180);
    pending_px.push_back(32'h0040_0040);
    wait_idle();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      write_column(cmpa_pkg::CFG_RED,   rand_column());
      write_column(cmpa_pkg::CFG_GREEN, rand_column());
      write_column(cmpa_pkg::CFG_BLUE,  rand_column());
      if ($urandom_range(0, 2) == 0) write_column(CFG_UNUSED, {$urandom, $urandom});
      @(negedge clk);
      for (int i = 0; i < PHASE_PIXELS; i++) pending_px.push_back(rand_pixel());
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
